### rtl/pce_pkg.sv
package pce_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned FRAME_W = 13;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned CIDX_W  = 2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd2;

  // Effect codes
  localparam logic [MODE_W-1:0] MODE_RED        = 4'd0;
  localparam logic [MODE_W-1:0] MODE_GREEN      = 4'd1;
  localparam logic [MODE_W-1:0] MODE_BLUE       = 4'd2;
  localparam logic [MODE_W-1:0] MODE_AVG_GREY   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_MAX_GREY   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_SEPIA      = 4'd5;
  localparam logic [MODE_W-1:0] MODE_BLUE_TINT  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_BLUE_WHITE = 4'd7;
  localparam logic [MODE_W-1:0] MODE_BLACK_SQ   = 4'd8;

  localparam logic [MODE_W-1:0]  RST_MODE   = MODE_RED;
  localparam logic [FRAME_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [FRAME_W-1:0] RST_HEIGHT = 13'd480;

  // Effect select and black square bounds, lo inclusive, hi exclusive
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FRAME_W-1:0] x_lo;
    logic [FRAME_W-1:0] x_hi;
    logic [FRAME_W-1:0] y_lo;
    logic [FRAME_W-1:0] y_hi;
  } pce_cfg_t;

  // floor(x/3) for x < 768: x*683 >> 11
  function automatic logic [CHAN_W-1:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // floor(x/5) for x < 1024: x*205 >> 10
  function automatic logic [CHAN_W-1:0] div5(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd205;
    return p[17:10];
  endfunction

  // floor(m*7/10) for m < 256: m*717 >> 10
  function automatic logic [CHAN_W-1:0] mul7div10(input logic [CHAN_W-1:0] m);
    logic [19:0] p;
    p = 20'(m) * 20'd717;
    return p[17:10];
  endfunction

  function automatic logic [CHAN_W-1:0] max3(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b,
                                             input logic [CHAN_W-1:0] c);
    logic [CHAN_W-1:0] m;
    m = (b > a) ? b : a;
    m = (c > m) ? c : m;
    return m;
  endfunction

endpackage

### rtl/pce_cfg.sv
module pce_cfg
  import pce_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [FRAME_W-1:0]  cfg_data,
  output pce_cfg_t            cfg
);

  localparam int unsigned XW = ($clog2(MAX_WIDTH + 1) > FRAME_W) ?
                               $clog2(MAX_WIDTH + 1) : FRAME_W;
  localparam int unsigned YW = ($clog2(MAX_HEIGHT + 1) > FRAME_W) ?
                               $clog2(MAX_HEIGHT + 1) : FRAME_W;
  localparam logic [XW-1:0] MAX_W_X = XW'(MAX_WIDTH);
  localparam logic [YW-1:0] MAX_H_Y = YW'(MAX_HEIGHT);

  logic [MODE_W-1:0]  mode_r;
  logic [FRAME_W-1:0] width_r;
  logic [FRAME_W-1:0] height_r;
  logic [FRAME_W-1:0] w_sat;
  logic [FRAME_W-1:0] h_sat;
  logic [FRAME_W+1:0] w3;
  logic [FRAME_W+1:0] h3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= RST_MODE;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode_r   <= cfg_data[MODE_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp frame size to the supported maximum
  always_comb begin
    w_sat = (XW'(width_r)  > MAX_W_X) ? MAX_W_X[FRAME_W-1:0] : width_r;
    h_sat = (YW'(height_r) > MAX_H_Y) ? MAX_H_Y[FRAME_W-1:0] : height_r;
    w3    = {1'b0, w_sat, 1'b0} + (FRAME_W+2)'(w_sat);
    h3    = {1'b0, h_sat, 1'b0} + (FRAME_W+2)'(h_sat);
  end

  assign cfg.mode = mode_r;
  assign cfg.x_lo = {2'b00, w_sat[FRAME_W-1:2]};
  assign cfg.x_hi = w3[FRAME_W+1:2];
  assign cfg.y_lo = {2'b00, h_sat[FRAME_W-1:2]};
  assign cfg.y_hi = h3[FRAME_W+1:2];

endmodule

### rtl/pce_effect.sv
module pce_effect
  import pce_pkg::*;
(
  input  pce_cfg_t             cfg,
  input  logic [COORD_W-1:0]   column,
  input  logic [COORD_W-1:0]   row,
  input  logic [CHAN_W-1:0]    red,
  input  logic [CHAN_W-1:0]    green,
  input  logic [CHAN_W-1:0]    blue,
  output logic [CHAN_W-1:0]    fx_red,
  output logic [CHAN_W-1:0]    fx_green,
  output logic [CHAN_W-1:0]    fx_blue
);

  logic [CHAN_W-1:0] m;
  logic [CHAN_W:0]   rg;
  logic [9:0]        rgb;
  logic [CHAN_W-1:0] rg25;
  logic [CHAN_W-1:0] sep_blue;
  logic              in_sq;

  always_comb begin
    m        = max3(red, green, blue);
    rg       = {1'b0, red} + {1'b0, green};
    rgb      = 10'(rg) + 10'(blue);
    rg25     = div5({rg, 1'b0});
    sep_blue = div5({1'b0, rg25, 1'b0});
    in_sq    = ({1'b0, column} >= cfg.x_lo) && ({1'b0, column} < cfg.x_hi) &&
               ({1'b0, row} >= cfg.y_lo) && ({1'b0, row} < cfg.y_hi);

    fx_red   = red;
    fx_green = green;
    fx_blue  = blue;
    unique case (cfg.mode)
      MODE_RED: begin
        fx_green = '0;
        fx_blue  = '0;
      end
      MODE_GREEN: begin
        fx_red  = '0;
        fx_blue = '0;
      end
      MODE_BLUE: begin
        fx_red   = '0;
        fx_green = '0;
      end
      MODE_AVG_GREY: begin
        fx_red   = div3(rgb);
        fx_green = fx_red;
        fx_blue  = fx_red;
      end
      MODE_MAX_GREY: begin
        fx_red   = m;
        fx_green = m;
        fx_blue  = m;
      end
      MODE_SEPIA: begin
        fx_red   = mul7div10(m);
        fx_green = fx_red;
        fx_blue  = sep_blue;
      end
      MODE_BLUE_TINT: begin
        fx_red   = div3(10'(rg));
        fx_green = fx_red;
        fx_blue  = m;
      end
      MODE_BLUE_WHITE: begin
        fx_red   = rg[CHAN_W:1];
        fx_green = fx_red;
        fx_blue  = m;
      end
      MODE_BLACK_SQ: begin
        if (in_sq) begin
          fx_red   = '0;
          fx_green = '0;
          fx_blue  = '0;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/pixel_colour_effect.sv
// Per-pixel colour effect unit.
// Requests: raise start with in_column, in_row, in_red, in_green, in_blue;
// the request is taken at each rising edge with start high and busy low.
// busy never rises, so a pixel can be issued on every clock.
// Results: out_valid marks out_red, out_green, out_blue for exactly one
// cycle per request, after the request has passed the input register,
// the effect logic and the result register. The receiver cannot stall;
// results come out in request order, one per request, at one per clock.
// Configuration: cfg_we with cfg_index 0 effect mode, 1 frame width,
// 2 frame height, cfg_data right-aligned. Write only while no request is
// in flight. Frame size is clamped to MAX_WIDTH and MAX_HEIGHT for the
// black square bounds.
// Reset (rst_n low, synchronous): mode 0 (red only), 640 x 480 frame,
// pipeline emptied, no strobe.
module pixel_colour_effect
  import pce_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [COORD_W-1:0]  in_column,
  input  logic [COORD_W-1:0]  in_row,
  input  logic [CHAN_W-1:0]   in_red,
  input  logic [CHAN_W-1:0]   in_green,
  input  logic [CHAN_W-1:0]   in_blue,
  output logic                out_valid,
  output logic [CHAN_W-1:0]   out_red,
  output logic [CHAN_W-1:0]   out_green,
  output logic [CHAN_W-1:0]   out_blue,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [FRAME_W-1:0]  cfg_data
);

  pce_cfg_t            cfg;
  logic                accept;
  logic                px_valid_r;
  logic [COORD_W-1:0]  px_col_r;
  logic [COORD_W-1:0]  px_row_r;
  logic [CHAN_W-1:0]   px_red_r;
  logic [CHAN_W-1:0]   px_green_r;
  logic [CHAN_W-1:0]   px_blue_r;
  logic [CHAN_W-1:0]   fx_red;
  logic [CHAN_W-1:0]   fx_green;
  logic [CHAN_W-1:0]   fx_blue;
  logic                out_valid_r;
  logic [CHAN_W-1:0]   out_red_r;
  logic [CHAN_W-1:0]   out_green_r;
  logic [CHAN_W-1:0]   out_blue_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  pce_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_valid_r <= 1'b0;
    end else begin
      px_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_col_r   <= in_column;
      px_row_r   <= in_row;
      px_red_r   <= in_red;
      px_green_r <= in_green;
      px_blue_r  <= in_blue;
    end
  end

  pce_effect u_effect (
    .cfg      (cfg),
    .column   (px_col_r),
    .row      (px_row_r),
    .red      (px_red_r),
    .green    (px_green_r),
    .blue     (px_blue_r),
    .fx_red   (fx_red),
    .fx_green (fx_green),
    .fx_blue  (fx_blue)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= px_valid_r;
    end
  end

  // Hold the last result when no request is in the input stage
  always_ff @(posedge clk) begin
    if (px_valid_r) begin
      out_red_r   <= fx_red;
      out_green_r <= fx_green;
      out_blue_r  <= fx_blue;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid_r)
    else $error("request did not produce a result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(px_valid_r))
    else $error("result strobe without a pixel in the input stage");

  a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (px_valid_r && (cfg.mode == MODE_AVG_GREY || cfg.mode == MODE_MAX_GREY))
      |=> (out_red_r == out_green_r) && (out_green_r == out_blue_r))
    else $error("grey effect produced unequal channels");

  a_red_only: assert property (@(posedge clk) disable iff (!rst_n)
    (px_valid_r && cfg.mode == MODE_RED)
      |=> (out_green_r == '0) && (out_blue_r == '0) && (out_red_r == $past(px_red_r)))
    else $error("red-only effect altered the wrong channels");

endmodule
